// File: hdl/phc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phc_pkg
// Shared types and codes for the polygon hole containment check.
// ----------------------------------------------------------------------------
package phc_pkg;
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FEW      = 3'd1;
	localparam logic [2:0] ST_AREA     = 3'd2;
	localparam logic [2:0] ST_OUTSIDE  = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	typedef enum logic [1:0] {
		OP_IDLE = 2'd0,
		OP_AREA = 2'd1,
		OP_RAY  = 2'd2
	} op_t;

	typedef struct packed {
		op_t  op;
		logic first;
		logic rd_hole;
	} dp_cmd_t;

	typedef struct packed {
		logic area_small;
		logic pt_in;
	} dp_stat_t;
endpackage

// File: hdl/phc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phc_datapath
// Vertex stores, shoelace accumulator and ray casting crossing test.
// Pipeline: read (s1), multiply (s2), accumulate/compare (s3).
// ----------------------------------------------------------------------------
module phc_datapath #(
	parameter int OW = 8,
	parameter int HW = 6,
	parameter int CB = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    o_we,
	input  logic [OW-1:0]           o_wa,
	input  logic                    h_we,
	input  logic [HW-1:0]           h_wa,
	input  logic signed [CB-1:0]    wx,
	input  logic signed [CB-1:0]    wy,
	input  logic [HW-1:0]           h_ra,
	input  logic [HW-1:0]           h_rb,
	input  logic [OW-1:0]           o_ra,
	input  logic [OW-1:0]           o_rb,
	input  logic [15:0]             tol,
	input  phc_pkg::dp_cmd_t        cmd,
	output phc_pkg::dp_stat_t       stat
);
	import phc_pkg::*;

	localparam int AW = 2*CB + 2 + HW;
	localparam int CW = (AW > 34) ? AW : 34;

	logic signed [CB-1:0] omx [2**OW];
	logic signed [CB-1:0] omy [2**OW];
	logic signed [CB-1:0] hmx [2**HW];
	logic signed [CB-1:0] hmy [2**HW];

	logic signed [CB-1:0] ax_s1, ay_s1, bx_s1, by_s1, px_s1, py_s1;
	dp_cmd_t              cmd_s1, cmd_s2;

	always_ff @(posedge clk) begin
		if (o_we) begin
			omx[o_wa] <= wx;
			omy[o_wa] <= wy;
		end
		if (h_we) begin
			hmx[h_wa] <= wx;
			hmy[h_wa] <= wy;
		end
		if (cmd.rd_hole) begin
			ax_s1 <= hmx[h_ra];
			ay_s1 <= hmy[h_ra];
			bx_s1 <= hmx[h_rb];
			by_s1 <= hmy[h_rb];
		end else begin
			ax_s1 <= omx[o_ra];
			ay_s1 <= omy[o_ra];
			bx_s1 <= omx[o_rb];
			by_s1 <= omy[o_rb];
		end
		px_s1 <= hmx[h_ra];
		py_s1 <= hmy[h_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			cmd_s2 <= '0;
		end else begin
			cmd_s1 <= cmd;
			cmd_s2 <= cmd_s1;
		end
	end

	// area: a = hole[i], b = hole[j]; ray: a = outline[i], b = outline[j]
	logic signed [CB:0]     dxp_c, dyp_c, dbx_c;
	logic signed [2*CB+1:0] m1_s2, m2_s2;
	logic                   dpos_s2, straddle_s2;
	logic                   straddle_c;

	assign dxp_c = (CB+1)'(px_s1) - (CB+1)'(ax_s1);
	assign dyp_c = (CB+1)'(py_s1) - (CB+1)'(ay_s1);
	assign dbx_c = (CB+1)'(bx_s1) - (CB+1)'(ax_s1);
	assign straddle_c = (ay_s1 > py_s1) != (by_s1 > py_s1);

	logic signed [CB:0] dd_c;
	assign dd_c = (CB+1)'(by_s1) - (CB+1)'(ay_s1);

	always_ff @(posedge clk) begin
		if (cmd_s1.op == OP_AREA) begin
			m1_s2 <= bx_s1 * ay_s1;
			m2_s2 <= ax_s1 * by_s1;
		end else begin
			m1_s2 <= dxp_c * dd_c;
			m2_s2 <= dyp_c * dbx_c;
		end
		dpos_s2     <= dd_c > 0;
		straddle_s2 <= straddle_c;
	end

	logic signed [AW-1:0] acc_q;
	logic                 in_q;
	logic signed [AW-1:0] acc_n;
	logic                 left_c;
	logic [AW-1:0]        mag_c;
	logic [33:0]          lim_c;

	assign acc_n  = (cmd_s2.first ? AW'(0) : acc_q) + AW'(m1_s2) - AW'(m2_s2);
	assign left_c = dpos_s2 ? (m1_s2 < m2_s2) : (m1_s2 > m2_s2);
	assign mag_c  = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
	assign lim_c  = {1'b0, 33'(tol) * 33'(tol)} << 1;

	always_ff @(posedge clk) begin
		unique case (cmd_s2.op)
			OP_AREA: acc_q <= acc_n;
			OP_RAY:  in_q  <= (cmd_s2.first ? 1'b0 : in_q) ^ (straddle_s2 & left_c);
			default: ;
		endcase
	end

	assign stat.area_small = CW'(mag_c) < CW'(lim_c);
	assign stat.pt_in      = in_q;
endmodule

// File: hdl/phc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phc_ctrl
// Vertex intake bookkeeping and check sequencer.
// ----------------------------------------------------------------------------
module phc_ctrl #(
	parameter int MO = 256,
	parameter int MH = 64,
	parameter int OW = 8,
	parameter int HW = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               accepted,
	output logic [2:0]         status,
	output logic               o_we,
	output logic [OW-1:0]      o_wa,
	output logic               h_we,
	output logic [HW-1:0]      h_wa,
	output logic [HW-1:0]      h_ra,
	output logic [HW-1:0]      h_rb,
	output logic [OW-1:0]      o_ra,
	output logic [OW-1:0]      o_rb,
	output phc_pkg::dp_cmd_t   cmd,
	input  phc_pkg::dp_stat_t  stat
);
	import phc_pkg::*;

	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_AREA = 3'd1;
	localparam logic [2:0] S_AWT  = 3'd2;
	localparam logic [2:0] S_RAY  = 3'd3;
	localparam logic [2:0] S_RWT  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]  state_q;
	logic [OW:0] ocnt_q;
	logic [HW:0] hcnt_q;
	logic        oclosed_q, oovf_q, hovf_q;
	logic [HW:0] i_q;
	logic [OW:0] k_q;
	logic [1:0]  w_q;
	logic        res_q;
	logic [2:0]  st_q;
	logic [2:0]  ost_q;

	logic take;
	logic post;
	assign in_ready = state_q == S_LOAD;
	assign take     = in_valid && in_ready;
	assign post     = (state_q == S_OUT) && (!res_q || out_ready);
	assign out_valid = res_q;
	assign status    = ost_q;
	assign accepted  = ost_q == ST_OK;

	logic [OW:0] ob_c;
	assign ob_c  = (kind == 1'b0 && oclosed_q) ? '0 : ocnt_q;
	assign o_we  = take && !kind && ob_c < (OW+1)'(MO);
	assign o_wa  = ob_c[OW-1:0];
	assign h_we  = take && kind && hcnt_q < (HW+1)'(MH);
	assign h_wa  = hcnt_q[HW-1:0];

	// area pass: a = hole[i], b = hole[i-1 wrap]; ray: point hole[i], edge k,k-1
	logic [HW:0] hprev_c;
	logic [OW:0] oprev_c;
	assign hprev_c = (i_q == '0) ? hcnt_q - 1'b1 : i_q - 1'b1;
	assign oprev_c = (k_q == '0) ? ocnt_q - 1'b1 : k_q - 1'b1;
	assign h_ra = i_q[HW-1:0];
	assign h_rb = hprev_c[HW-1:0];
	assign o_ra = k_q[OW-1:0];
	assign o_rb = oprev_c[OW-1:0];

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_AREA: begin
				cmd.op = OP_AREA; cmd.rd_hole = 1'b1; cmd.first = i_q == '0;
			end
			S_RAY: begin
				cmd.op = OP_RAY; cmd.first = k_q == '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD; ocnt_q <= '0; hcnt_q <= '0; oclosed_q <= 1'b0;
			oovf_q <= 1'b0; hovf_q <= 1'b0; i_q <= '0; k_q <= '0; w_q <= '0;
			res_q <= 1'b0; st_q <= ST_OK; ost_q <= ST_OK;
		end else begin
			if (post) res_q <= 1'b1;
			else if (res_q && out_ready) res_q <= 1'b0;
			unique case (state_q)
				S_LOAD: if (take) begin
					if (!kind) begin
						if (oclosed_q) oovf_q <= 1'b0;
						if (ob_c < (OW+1)'(MO)) ocnt_q <= ob_c + 1'b1;
						else begin
							ocnt_q <= ob_c; oovf_q <= 1'b1;
						end
						oclosed_q <= last;
					end else begin
						oclosed_q <= 1'b1;
						if (hcnt_q < (HW+1)'(MH)) hcnt_q <= hcnt_q + 1'b1;
						else hovf_q <= 1'b1;
						if (last) begin
							i_q <= '0; k_q <= '0;
							if (hovf_q || oovf_q || hcnt_q >= (HW+1)'(MH)) begin
								st_q <= ST_OVERFLOW; state_q <= S_OUT;
							end else if (hcnt_q + 1'b1 < (HW+1)'(3)) begin
								st_q <= ST_FEW; state_q <= S_OUT;
							end else state_q <= S_AREA;
						end
					end
				end
				S_AREA: begin
					w_q <= '0;
					if (i_q == hcnt_q - 1'b1) state_q <= S_AWT;
					else i_q <= i_q + 1'b1;
				end
				S_AWT: begin
					w_q <= w_q + 1'b1;
					if (w_q == 2'd3) begin
						i_q <= '0;
						if (stat.area_small) begin
							st_q <= ST_AREA; state_q <= S_OUT;
						end else state_q <= (ocnt_q == '0) ? S_OUT : S_RAY;
						if (!stat.area_small && ocnt_q == '0) st_q <= ST_OUTSIDE;
					end
				end
				S_RAY: begin
					w_q <= '0;
					if (k_q == ocnt_q - 1'b1) state_q <= S_RWT;
					else k_q <= k_q + 1'b1;
				end
				S_RWT: begin
					w_q <= w_q + 1'b1;
					if (w_q == 2'd3) begin
						k_q <= '0;
						if (!stat.pt_in) begin
							st_q <= ST_OUTSIDE; state_q <= S_OUT;
						end else if (i_q == hcnt_q - 1'b1) begin
							st_q <= ST_OK; state_q <= S_OUT;
						end else begin
							i_q <= i_q + 1'b1; state_q <= S_RAY;
						end
					end
				end
				S_OUT: if (post) begin
					ost_q <= st_q; hcnt_q <= '0; hovf_q <= 1'b0; state_q <= S_LOAD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule

// File: hdl/polygon_hole_containment_check.sv
`timescale 1ns / 1ps
// Outline and non-last hole vertices are taken one per cycle while in_ready is high.
// After the final hole vertex come the area pass over the hole, then, where needed,
// ray casting of each hole vertex against the outline edges through the single shared
// crossing-test pipeline, then the result is posted. Intake stalls
// during the check and while a new result waits behind an untaken one.
// Reset clears counts, flags and tolerance (to 1); vertex stores are undefined.
// ----------------------------------------------------------------------------
// polygon_hole_containment_check
// Top level: hole polygon validity and containment against a stored outline.
// ----------------------------------------------------------------------------
module polygon_hole_containment_check #(
	parameter int MAX_OUTLINE_VERTICES = 256,
	parameter int MAX_HOLE_VERTICES    = 64,
	parameter int COORD_BITS           = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         accepted,
	output logic [2:0]                   status,
	input  logic                         cfg_we,
	input  logic [15:0]                  cfg_wdata
);
	import phc_pkg::*;

	localparam int OW = $clog2(MAX_OUTLINE_VERTICES);
	localparam int HW = $clog2(MAX_HOLE_VERTICES);

	logic [15:0] tol_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tol_q <= 16'd1;
		else if (cfg_we) tol_q <= cfg_wdata;
	end

	logic o_we, h_we;
	logic [OW-1:0] o_wa, o_ra, o_rb;
	logic [HW-1:0] h_wa, h_ra, h_rb;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	phc_ctrl #(.MO(MAX_OUTLINE_VERTICES), .MH(MAX_HOLE_VERTICES), .OW(OW), .HW(HW)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .kind, .last, .out_valid, .out_ready,
		.accepted, .status, .o_we, .o_wa, .h_we, .h_wa, .h_ra, .h_rb, .o_ra, .o_rb,
		.cmd, .stat
	);

	phc_datapath #(.OW(OW), .HW(HW), .CB(COORD_BITS)) u_dp (
		.clk, .arst_n, .o_we, .o_wa, .h_we, .h_wa, .wx(x_coord), .wy(y_coord),
		.h_ra, .h_rb, .o_ra, .o_rb, .tol(tol_q), .cmd, .stat
	);

	a_acc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accepted == (status == ST_OK))) else $error("accepted mismatch");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped or changed while waiting");
	a_status_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_OVERFLOW)) else $error("bad status");
endmodule
